>>> hdl/texture_sampler_bilinear_core_defines.svh
// Assertion macros used by the texture sampler queue
`ifndef TEXTURE_SAMPLER_BILINEAR_CORE_DEFINES_SVH
`define TEXTURE_SAMPLER_BILINEAR_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define TSB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsb assertion failed");

// next-cycle implication
`define TSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsb assertion failed");

`endif

>>> hdl/tsb_pkg.sv
// Shared types and constants of the texture sampler
package tsb_pkg;

  localparam int TEXEL_DEPTH_DEF = 65536;
  localparam int MAX_SIDE_DEF    = 256;
  localparam int FRAC_BITS_DEF   = 16;

  // entries of the front/back queue
  localparam int QUEUE_DEPTH = 8;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_FILL,
    KIND_SINGLE,
    KIND_BLEND
  } kind_t;

  typedef enum logic [2:0] {
    REG_TEX_WIDTH  = 3'd0,
    REG_TEX_HEIGHT = 3'd1,
    REG_SURROUND   = 3'd2,
    REG_FILTER     = 3'd3,
    REG_FILL       = 3'd4
  } reg_idx_t;

  localparam logic [1:0] SURR_FILL   = 2'd1;
  localparam logic [1:0] SURR_REPEAT = 2'd2;
  localparam logic       CMD_WRITE   = 1'b0;
  localparam logic       FILT_BILIN  = 1'b1;

endpackage

>>> hdl/tsb_queue.sv
// Small FIFO between the front and back parts
module tsb_queue import tsb_pkg::*; #(
  parameter int W = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic [W-1:0]                       push_data,
  input  logic                               pop,
  output logic [W-1:0]                       pop_data,
  output logic                               empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH+1);

  logic [W-1:0]    slots [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic            full;

  assign empty    = (count == '0);
  assign full     = (count == CNTW'(QUEUE_DEPTH));
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`include "texture_sampler_bilinear_core_defines.svh"

  `TSB_ASSERT_NOW(a_no_overflow, push, !full || pop)
  `TSB_ASSERT_NOW(a_no_underflow, pop, !empty)
  `TSB_ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

>>> hdl/tsb_front.sv
// Front part: accepts items, resolves surround and filter, forms base address
module tsb_front import tsb_pkg::*; #(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [15:0]                       texel_index,
  input  logic [31:0]                       texel_value,
  input  logic signed [31:0]                u_coord,
  input  logic signed [31:0]                v_coord,
  input  logic [8:0]                        tex_width,
  input  logic [8:0]                        tex_height,
  input  logic [1:0]                        surround_mode,
  input  logic                              filter_mode,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count,
  output logic                              push,
  output logic [2+2*(2*$clog2(MAX_SIDE+1)+1)/2+$clog2(MAX_SIDE+1)+2*FRAC_BITS+48-1:0]
                                            push_data
);

  localparam int CW   = FRAC_BITS + 1;
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int PW   = CW + SW;
  localparam int AW   = 2 * SW + 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1) + 3;
  localparam logic signed [31:0] ONE_S     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] FRAC_MASK = ONE_S - 32'sd1;

  function automatic logic [SW-1:0] side_limit(input logic [8:0] s);
    if (s == 9'd0) return SW'(1);
    if (int'(s) > MAX_SIDE) return SW'(MAX_SIDE);
    return SW'(s);
  endfunction

  function automatic logic [CW-1:0] fix_coord(input logic signed [31:0] c, input logic rep);
    logic signed [31:0] t;
    t = rep ? (c & FRAC_MASK) : c;
    if (t < 32'sd0) return '0;
    if (t > ONE_S) return CW'(ONE_S);
    return CW'(t);
  endfunction

  logic accept;
  assign accept = start && !busy;

  // stage A: captured item
  logic               a_vld, a_cmd;
  logic [15:0]        a_idx;
  logic [31:0]        a_val;
  logic signed [31:0] a_u, a_v;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else a_vld <= accept;
    if (accept) begin
      a_cmd <= command;
      a_idx <= texel_index;
      a_val <= texel_value;
      a_u   <= u_coord;
      a_v   <= v_coord;
    end
  end

  // stage B: range test, surround handling
  logic        oob, rep;
  kind_t       b_kind_next;
  logic        b_vld;
  kind_t       b_kind;
  logic [CW-1:0] b_u, b_v;
  logic [SW-1:0] b_w, b_h;
  logic [15:0] b_idx;
  logic [31:0] b_val;

  always_comb begin
    oob = a_u[31] || (a_u > ONE_S) || a_v[31] || (a_v > ONE_S);
    rep = oob && (surround_mode == SURR_REPEAT);
    if (a_cmd == CMD_WRITE) b_kind_next = KIND_WRITE;
    else if (oob && surround_mode == SURR_FILL) b_kind_next = KIND_FILL;
    else if (filter_mode == FILT_BILIN) b_kind_next = KIND_BLEND;
    else b_kind_next = KIND_SINGLE;
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else b_vld <= a_vld;
    b_kind <= b_kind_next;
    b_u    <= fix_coord(a_u, rep);
    b_v    <= fix_coord(a_v, rep);
    b_w    <= side_limit(tex_width);
    b_h    <= side_limit(tex_height);
    b_idx  <= a_idx;
    b_val  <= a_val;
  end

  // stage C: scale coordinates by side (or side-1 for bilinear)
  logic [SW-1:0] mw, mh;
  logic          c_vld;
  kind_t         c_kind;
  logic [PW-1:0] c_px, c_py;
  logic [SW-1:0] c_w, c_h;
  logic [15:0]   c_idx;
  logic [31:0]   c_val;

  assign mw = (b_kind == KIND_BLEND) ? b_w - 1'b1 : b_w;
  assign mh = (b_kind == KIND_BLEND) ? b_h - 1'b1 : b_h;

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else c_vld <= b_vld;
    c_kind <= b_kind;
    c_px   <= PW'(b_u) * PW'(mw);
    c_py   <= PW'(b_v) * PW'(mh);
    c_w    <= b_w;
    c_h    <= b_h;
    c_idx  <= b_idx;
    c_val  <= b_val;
  end

  // stage D: texel position and weights
  logic [SW:0]    x1, y1, wm1, hm1, xs, ys;
  logic [FRAC_BITS-1:0] fu_n, fv_n;
  kind_t          d_kind_next;
  logic           d_vld;
  kind_t          d_kind;
  logic [SW-1:0]  d_x, d_y, d_w;
  logic [FRAC_BITS-1:0] d_fu, d_fv;
  logic [15:0]    d_idx;
  logic [31:0]    d_val;

  always_comb begin
    x1  = c_px[PW-1:FRAC_BITS];
    y1  = c_py[PW-1:FRAC_BITS];
    wm1 = (SW+1)'(c_w) - 1'b1;
    hm1 = (SW+1)'(c_h) - 1'b1;
    xs  = x1;
    ys  = y1;
    fu_n = '0;
    fv_n = '0;
    d_kind_next = c_kind;
    case (c_kind)
      KIND_SINGLE: begin
        if (x1 > wm1) xs = wm1;
        if (y1 > hm1) ys = hm1;
      end
      KIND_BLEND: begin
        if (x1 >= wm1 || y1 >= hm1) begin
          d_kind_next = KIND_SINGLE;
        end else begin
          fu_n = c_px[FRAC_BITS-1:0];
          fv_n = c_py[FRAC_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else d_vld <= c_vld;
    d_kind <= d_kind_next;
    d_x    <= xs[SW-1:0];
    d_y    <= ys[SW-1:0];
    d_w    <= c_w;
    d_fu   <= fu_n;
    d_fv   <= fv_n;
    d_idx  <= c_idx;
    d_val  <= c_val;
  end

  // stage E: row-major base address
  logic           e_vld;
  kind_t          e_kind;
  logic [AW-1:0]  e_base;
  logic [SW-1:0]  e_w;
  logic [FRAC_BITS-1:0] e_fu, e_fv;
  logic [15:0]    e_idx;
  logic [31:0]    e_val;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else e_vld <= d_vld;
    e_kind <= d_kind;
    e_base <= AW'(d_y) * AW'(d_w) + AW'(d_x);
    e_w    <= d_w;
    e_fu   <= d_fu;
    e_fv   <= d_fv;
    e_idx  <= d_idx;
    e_val  <= d_val;
  end

  assign push      = e_vld;
  assign push_data = {e_kind, e_base, e_w, e_fu, e_fv, e_idx, e_val};

  // hold off when queue plus items in flight could overrun the queue
  logic [CNTW-1:0] in_flight;
  assign in_flight = CNTW'(a_vld) + CNTW'(b_vld) + CNTW'(c_vld) + CNTW'(d_vld) + CNTW'(e_vld);
  assign busy = (CNTW'(q_count) + in_flight) >= CNTW'(QUEUE_DEPTH);

endmodule

>>> hdl/tsb_back.sv
// Back part: texel store, four-way fetch, bilinear blend
module tsb_back import tsb_pkg::*; #(
  parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  output logic        pop,
  input  logic [2+2*(2*$clog2(MAX_SIDE+1)+1)/2+$clog2(MAX_SIDE+1)+2*FRAC_BITS+48-1:0]
                      pop_data,
  input  logic [31:0] fill_color,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha
);

  localparam int CW   = FRAC_BITS + 1;
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int AW   = 2 * SW + 1;
  localparam int MAW  = $clog2(TEXEL_DEPTH);
  localparam int RX   = ((AW > MAW) ? AW : MAW) + 1;
  localparam int XW   = (MAW > 16) ? MAW : 16;
  localparam int TW   = CW + 9;
  localparam int SWD  = TW + CW + 1;
  localparam int CHW  = SWD - 2 * FRAC_BITS;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  // queue entry fields
  kind_t         q_kind;
  logic [AW-1:0] q_base;
  logic [SW-1:0] q_w;
  logic [FRAC_BITS-1:0] q_fu, q_fv;
  logic [15:0]   q_idx;
  logic [31:0]   q_val;

  assign {q_kind, q_base, q_w, q_fu, q_fv, q_idx, q_val} = pop_data;
  assign pop = !empty;

  // four corner addresses
  logic [AW-1:0] addr [4];
  logic [3:0]    addr_ok;
  logic          wr_en, rd_en;
  logic [XW-1:0] idx_ext;

  assign addr[0] = q_base;
  assign addr[1] = q_base + 1'b1;
  assign addr[2] = q_base + AW'(q_w);
  assign addr[3] = q_base + AW'(q_w) + 1'b1;
  assign wr_en   = pop && (q_kind == KIND_WRITE) && (32'(q_idx) < 32'(TEXEL_DEPTH));
  assign rd_en   = pop && (q_kind != KIND_WRITE);
  assign idx_ext = XW'(q_idx);

  // one store copy per corner, all written together
  logic [31:0] rd_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_copy
    logic [31:0]   mem [TEXEL_DEPTH];
    logic [RX-1:0] a_ext;

    assign a_ext      = RX'(addr[k]);
    assign addr_ok[k] = a_ext < RX'(TEXEL_DEPTH);

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[idx_ext[MAW-1:0]] <= q_val;
      end
      if (rd_en) begin
        rd_q[k] <= mem[a_ext[MAW-1:0]];
      end
    end
  end

  // stage M: read data arrives
  logic          m_vld;
  kind_t         m_kind;
  logic [FRAC_BITS-1:0] m_fu, m_fv;
  logic [3:0]    m_ok;

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else m_vld <= rd_en;
    m_kind <= q_kind;
    m_fu   <= q_fu;
    m_fv   <= q_fv;
    m_ok   <= addr_ok;
  end

  logic [31:0]   tx [4];
  logic [CW-1:0] gu, fu_c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tx[k] = m_ok[k] ? rd_q[k] : 32'd0;
    end
    if (m_kind == KIND_FILL) tx[0] = fill_color;
    fu_c = CW'(m_fu);
    gu   = ONE_C - fu_c;
  end

  // stage B1/B2/B3 per channel
  logic          b1_vld, b2_vld;
  logic [CW-1:0] b1_gv, b1_fv;
  logic [7:0]    chan [4];

  for (genvar c = 0; c < 4; c++) begin : g_chan
    logic [TW-1:0]  t0, t1;
    logic [SWD-1:0] s;
    logic [CHW-1:0] hi;

    // horizontal mix of the two rows
    always_ff @(posedge clk) begin
      t0 <= TW'(tx[0][8*c +: 8]) * TW'(gu) + TW'(tx[1][8*c +: 8]) * TW'(fu_c);
      t1 <= TW'(tx[2][8*c +: 8]) * TW'(gu) + TW'(tx[3][8*c +: 8]) * TW'(fu_c);
    end

    // vertical mix
    always_ff @(posedge clk) begin
      s <= SWD'(t0) * SWD'(b1_gv) + SWD'(t1) * SWD'(b1_fv);
    end

    // floor and saturate
    assign hi = s[SWD-1:2*FRAC_BITS];
    always_ff @(posedge clk) begin
      chan[c] <= (hi > CHW'(255)) ? 8'hff : hi[7:0];
    end
  end

  always_ff @(posedge clk) begin
    b1_gv <= ONE_C - CW'(m_fv);
    b1_fv <= CW'(m_fv);
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      b1_vld <= m_vld;
      b2_vld <= b1_vld;
      done   <= b2_vld;
    end
  end

  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];
  assign alpha = chan[3];

endmodule

>>> hdl/texture_sampler_bilinear_core.sv
// Top level of the bilinear texture sampler: config registers and part wiring
//
// Usage: an item is taken at a rising edge with start high and busy low.
// command 0 writes texel_value into the texture at texel_index and gives
// no result; command 1 samples at the Q15.16 coordinates u_coord, v_coord.
// Each sample gives one RGBA result on red/green/blue/alpha, marked by done
// for exactly one cycle; the receiver cannot stall, so results never wait.
// From accept to done an item passes five front stages, the queue, the
// registered store read and three blend stages. One item per cycle is
// sustained while busy stays low; the front and back parts are fully
// pipelined and the queue between them absorbs bubbles, so busy only rises
// if the queue could overrun.
// Registers sit on an APB port at byte addresses 0,4,8,12,16: width,
// height, surround mode, filter mode, fill color. Write them only while
// the block is idle.
// Reset clears the pipeline and queue and sets width and height to 1, the
// other registers to 0. Texture contents are undefined until written.
module texture_sampler_bilinear_core import tsb_pkg::*; #(
  parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [15:0]        texel_index,
  input  logic [31:0]        texel_value,
  input  logic signed [31:0] u_coord,
  input  logic signed [31:0] v_coord,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int EW = 2 + 2*(2*$clog2(MAX_SIDE+1)+1)/2 + $clog2(MAX_SIDE+1)
                      + 2*FRAC_BITS + 48;

  // config registers
  logic [8:0]  tex_width, tex_height;
  logic [1:0]  surround_mode;
  logic        filter_mode;
  logic [31:0] fill_color;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width     <= 9'd1;
      tex_height    <= 9'd1;
      surround_mode <= 2'd0;
      filter_mode   <= 1'b0;
      fill_color    <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEX_WIDTH:  tex_width     <= pwdata[8:0];
        REG_TEX_HEIGHT: tex_height    <= pwdata[8:0];
        REG_SURROUND:   surround_mode <= pwdata[1:0];
        REG_FILTER:     filter_mode   <= pwdata[0];
        REG_FILL:       fill_color    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_TEX_WIDTH:  prdata = {23'd0, tex_width};
      REG_TEX_HEIGHT: prdata = {23'd0, tex_height};
      REG_SURROUND:   prdata = {30'd0, surround_mode};
      REG_FILTER:     prdata = {31'd0, filter_mode};
      REG_FILL:       prdata = fill_color;
      default:        prdata = 32'd0;
    endcase
  end

  logic                              push, pop, q_empty;
  logic [EW-1:0]                     push_data, pop_data;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count;

  tsb_front #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .texel_index   (texel_index),
    .texel_value   (texel_value),
    .u_coord       (u_coord),
    .v_coord       (v_coord),
    .tex_width     (tex_width),
    .tex_height    (tex_height),
    .surround_mode (surround_mode),
    .filter_mode   (filter_mode),
    .q_count       (q_count),
    .push          (push),
    .push_data     (push_data)
  );

  tsb_queue #(
    .W (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  tsb_back #(
    .TEXEL_DEPTH (TEXEL_DEPTH),
    .MAX_SIDE    (MAX_SIDE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .pop        (pop),
    .pop_data   (pop_data),
    .fill_color (fill_color),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha)
  );

endmodule
